[hdl/gfel_pkg.sv]
package gfel_pkg;

   // Register indexes of the configuration port
   localparam logic CSR_EARTH_RADIUS   = 1'b0;
   localparam logic CSR_MOVE_THRESHOLD = 1'b1;

   localparam logic [22:0] EARTH_RADIUS_RESET   = 23'd6371000;
   localparam logic [15:0] MOVE_THRESHOLD_RESET = 16'd500;

   // Scaling constants, derived from pi in Q60
   localparam logic [40:0] K_NS          = 41'd2012227627243;
   localparam logic [32:0] K_DEG2RAD     = 33'd8048910508;
   localparam logic [31:0] BAM_K         = 32'd2734261102;
   localparam logic [30:0] HALF_PI_Q30   = 31'd1686629713;
   localparam logic [29:0] CORDIC_INV_GAIN = 30'd652032874;
   localparam logic [30:0] NINETY_DEG_E7 = 31'd900000000;
   localparam logic [30:0] HALF_TURN_E7  = 31'd1800000000;

   // Command to the serial multiplier
   typedef struct packed {
      logic       start;
      logic [6:0] cycles;
      logic       round_en;
      logic [6:0] round_bit;
   } mul_cmd_type;

   // Arctangent table in Q30: exact values for the first ten steps, then 2^(30-i)
   function automatic logic [29:0] atan_q30(input logic [4:0] i);
      logic [29:0] r;
      case (i)
         5'd0:    r = 30'h3243F6A8;
         5'd1:    r = 30'h1DAC6705;
         5'd2:    r = 30'h0FADBAFC;
         5'd3:    r = 30'h07F56EA6;
         5'd4:    r = 30'h03FEAB76;
         5'd5:    r = 30'h01FFD55B;
         5'd6:    r = 30'h00FFFAAA;
         5'd7:    r = 30'h007FFF55;
         5'd8:    r = 30'h003FFFEA;
         5'd9:    r = 30'h001FFFFD;
         5'd31:   r = '0;
         default: r = 30'd1 << (5'd30 - i);
      endcase
      return r;
   endfunction

   // Apply a sign to a magnitude and clamp to 32 bits
   function automatic logic [31:0] sat32(input logic [63:0] m, input logic neg);
      logic [63:0] n;
      logic [31:0] r;
      n = ~m + 64'd1;
      if (neg) begin
         r = (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : n[31:0];
      end else begin
         r = (m > 64'h0000_0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
      end
      return r;
   endfunction

endpackage

[hdl/gfel_if.sv]
interface gfel_req_if;
   logic               valid;
   logic               ready;
   logic signed [30:0] latitude_e7;
   logic signed [31:0] longitude_e7;
   logic        [17:0] ground_speed_mm_s;

   modport source (output valid, latitude_e7, longitude_e7, ground_speed_mm_s, input ready);
   modport sink   (input valid, latitude_e7, longitude_e7, ground_speed_mm_s, output ready);
endinterface

interface gfel_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] east_mm;
   logic signed [31:0] north_mm;
   logic signed [15:0] heading_bam;
   logic               origin_fix;

   modport source (output valid, east_mm, north_mm, heading_bam, origin_fix, input ready);
   modport sink   (input valid, east_mm, north_mm, heading_bam, origin_fix, output ready);
endinterface

[hdl/gfel_mul.sv]
module gfel_mul
   import gfel_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  mul_cmd_type   cmd,
   input  logic [63:0]   a,
   input  logic [63:0]   b,
   output logic          done,
   output logic [127:0]  product
);

   logic [127:0] a_ff, a_in;
   logic [63:0]  b_ff, b_in;
   logic [127:0] p_ff, p_in;
   logic [6:0]   cnt_ff, cnt_in;
   logic         busy_ff, busy_in;
   logic         done_ff, done_in;

   // Shift-add: one multiplier bit per cycle, starting at the rounding offset
   always_comb begin
      a_in    = a_ff;
      b_in    = b_ff;
      p_in    = p_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         a_in    = {64'd0, a};
         b_in    = b;
         p_in    = cmd.round_en ? (128'd1 << cmd.round_bit) : '0;
         cnt_in  = cmd.cycles;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (b_ff[0]) begin
            p_in = p_ff + a_ff;
         end
         a_in   = a_ff << 1;
         b_in   = b_ff >> 1;
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      p_ff   <= p_in;
      cnt_ff <= cnt_in;
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

[hdl/gps_flat_earth_localiser_top.sv]
// Channel   Direction  Handshake          Word
// req_      in         valid/ready        latitude_e7, longitude_e7, ground_speed_mm_s
// rsp_      out        valid/ready        east_mm, north_mm, heading_bam, origin_fix
// csr_      in         write, no ready    csr_index, csr_data
//
// One fix at a time. The origin fix goes straight to the result word. Any later fix
// runs six bit-serial multiplies on one shared shift-add unit (23+23+41+41+33+32
// bits) and N CORDIC steps for the cosine; a heading update adds N atan2 steps
// and one 32-bit multiply, with N = min(CORDIC_ITERATIONS, 32). Reset is synchronous
// and needs no clearing pass. A stalled result register holds one word and still
// lets the next fix in.
module gps_flat_earth_localiser_top
   import gfel_pkg::*;
#(
   parameter int CORDIC_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   gfel_req_if.sink    req_channel,
   gfel_rsp_if.source  rsp_channel,
   input  logic        csr_write,
   input  logic        csr_index,
   input  logic [22:0] csr_data
);

   localparam int ITER = (CORDIC_ITERATIONS < 32) ? CORDIC_ITERATIONS : 32;
   localparam logic [4:0] LAST_STEP = 5'(ITER - 1);

   typedef enum logic [11:0] {
      S_IDLE  = 12'b0000_0000_0001,
      S_PN    = 12'b0000_0000_0010,
      S_PE    = 12'b0000_0000_0100,
      S_NORTH = 12'b0000_0000_1000,
      S_E20   = 12'b0000_0001_0000,
      S_THETA = 12'b0000_0010_0000,
      S_COS   = 12'b0000_0100_0000,
      S_EAST  = 12'b0000_1000_0000,
      S_HEAD  = 12'b0001_0000_0000,
      S_ATAN  = 12'b0010_0000_0000,
      S_BAM   = 12'b0100_0000_0000,
      S_DONE  = 12'b1000_0000_0000
   } state_type;

   state_type state_ff, state_in;
   logic      wait_ff, wait_in;

   logic [22:0] radius_ff, radius_in;
   logic [15:0] threshold_ff, threshold_in;

   logic               origin_set_ff, origin_set_in;
   logic signed [30:0] origin_lat_ff, origin_lat_in;
   logic signed [31:0] origin_lon_ff, origin_lon_in;
   logic signed [31:0] prev_east_ff, prev_east_in;
   logic signed [31:0] prev_north_ff, prev_north_in;
   logic signed [15:0] heading_ff, heading_in;

   logic [31:0] dlat_mag_ff, dlat_mag_in;
   logic        dlat_neg_ff, dlat_neg_in;
   logic [32:0] dlon_mag_ff, dlon_mag_in;
   logic        dlon_neg_ff, dlon_neg_in;
   logic [30:0] amean_ff, amean_in;
   logic        fold_ff, fold_in;
   logic [17:0] speed_ff, speed_in;
   logic        fix_ff, fix_in;

   logic [53:0] pn_ff, pn_in;
   logic [55:0] pe_ff, pe_in;
   logic [56:0] e20_ff, e20_in;
   logic signed [31:0] east_ff, east_in;
   logic signed [31:0] north_ff, north_in;

   logic signed [59:0] cx_ff, cx_in, cy_ff, cy_in;
   logic signed [33:0] cz_ff, cz_in;
   logic [4:0]         ci_ff, ci_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_east_ff, rsp_east_in;
   logic signed [31:0] rsp_north_ff, rsp_north_in;
   logic signed [15:0] rsp_heading_ff, rsp_heading_in;
   logic               rsp_fix_ff, rsp_fix_in;

   mul_cmd_type  mul_cmd;
   logic [63:0]  mul_a, mul_b;
   logic         mul_done;
   logic [127:0] mul_p;

   // Accept-side arithmetic
   logic signed [31:0] dlat;
   logic signed [32:0] dlon;
   logic signed [31:0] lat_sum, lat_sum_adj;
   logic signed [30:0] mean;
   logic [30:0]        mean_mag;
   logic               mean_fold;

   // Heading-side arithmetic
   logic signed [32:0] dx, dy;
   logic               moved, update;
   logic signed [59:0] x0, y0;

   // CORDIC step
   logic signed [59:0] xs, ys;
   logic signed [33:0] at;
   logic               rot, cpos;
   logic signed [59:0] cx_step, cy_step;
   logic signed [33:0] cz_step;
   logic [31:0]        c_mag;
   logic [33:0]        z_mag;
   logic [63:0]        bam_m;
   logic [15:0]        bam_neg;

   gfel_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .cmd     (mul_cmd),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (mul_p)
   );

   // Differences to the origin and folded mean latitude
   always_comb begin
      dlat        = 32'(req_channel.latitude_e7) - 32'(origin_lat_ff);
      dlon        = 33'(req_channel.longitude_e7) - 33'(origin_lon_ff);
      lat_sum     = 32'(req_channel.latitude_e7) + 32'(origin_lat_ff);
      lat_sum_adj = lat_sum + 32'(lat_sum[31]);
      mean        = 31'(lat_sum_adj >>> 1);
      mean_mag    = mean[30] ? 31'(-mean) : 31'(mean);
      mean_fold   = mean_mag > NINETY_DEG_E7;
   end

   // Step since the last position and the atan2 start vector
   always_comb begin
      dx    = 33'(east_ff) - 33'(prev_east_ff);
      dy    = 33'(north_ff) - 33'(prev_north_ff);
      moved = (dx > 33'sd1) || (dx < -33'sd1) || (dy > 33'sd1) || (dy < -33'sd1);
      update = ({2'b00, threshold_ff} < speed_ff) && moved;
      x0 = 60'(dx) <<< 24;
      y0 = 60'(dy) <<< 24;
   end

   // One CORDIC micro-rotation
   always_comb begin
      xs   = cx_ff >>> ci_ff;
      ys   = cy_ff >>> ci_ff;
      at   = signed'({4'b0000, atan_q30(ci_ff)});
      rot  = (state_ff == S_COS);
      cpos = rot ? !cz_ff[33] : (cy_ff[59] || (cy_ff == '0));
      if (cpos) begin
         cx_step = cx_ff - ys;
         cy_step = cy_ff + xs;
         cz_step = cz_ff - at;
      end else begin
         cx_step = cx_ff + ys;
         cy_step = cy_ff - xs;
         cz_step = cz_ff + at;
      end
      c_mag   = cx_ff[59] ? 32'(-cx_ff) : 32'(cx_ff);
      z_mag   = cz_ff[33] ? 34'(-cz_ff) : 34'(cz_ff);
      bam_m   = mul_p[111:48];
      bam_neg = 16'd0 - bam_m[15:0];
   end

   // Operands for the serial multiplier
   always_comb begin
      mul_a   = '0;
      mul_b   = '0;
      mul_cmd = '0;
      unique case (state_ff)
         S_PN: begin
            mul_a = 64'(dlat_mag_ff);
            mul_b = 64'(radius_ff);
            mul_cmd.cycles = 7'd23;
         end
         S_PE: begin
            mul_a = 64'(dlon_mag_ff);
            mul_b = 64'(radius_ff);
            mul_cmd.cycles = 7'd23;
         end
         S_NORTH: begin
            mul_a = 64'(pn_ff);
            mul_b = 64'(K_NS);
            mul_cmd.cycles    = 7'd41;
            mul_cmd.round_en  = 1'b1;
            mul_cmd.round_bit = 7'd59;
         end
         S_E20: begin
            mul_a = 64'(pe_ff);
            mul_b = 64'(K_NS);
            mul_cmd.cycles    = 7'd41;
            mul_cmd.round_en  = 1'b1;
            mul_cmd.round_bit = 7'd39;
         end
         S_THETA: begin
            mul_a = 64'(amean_ff);
            mul_b = 64'(K_DEG2RAD);
            mul_cmd.cycles    = 7'd33;
            mul_cmd.round_en  = 1'b1;
            mul_cmd.round_bit = 7'd31;
         end
         S_EAST: begin
            mul_a = 64'(e20_ff);
            mul_b = 64'(c_mag);
            mul_cmd.cycles    = 7'd32;
            mul_cmd.round_en  = 1'b1;
            mul_cmd.round_bit = 7'd49;
         end
         S_BAM: begin
            mul_a = 64'(z_mag);
            mul_b = 64'(BAM_K);
            mul_cmd.cycles    = 7'd32;
            mul_cmd.round_en  = 1'b1;
            mul_cmd.round_bit = 7'd47;
         end
         default: begin
            mul_cmd.cycles = '0;
         end
      endcase
      mul_cmd.start = !wait_ff && (state_ff == S_PN || state_ff == S_PE ||
                      state_ff == S_NORTH || state_ff == S_E20 || state_ff == S_THETA ||
                      state_ff == S_EAST || state_ff == S_BAM);
   end

   // Sequencer
   always_comb begin
      state_in       = state_ff;
      wait_in        = wait_ff;
      radius_in      = radius_ff;
      threshold_in   = threshold_ff;
      origin_set_in  = origin_set_ff;
      origin_lat_in  = origin_lat_ff;
      origin_lon_in  = origin_lon_ff;
      prev_east_in   = prev_east_ff;
      prev_north_in  = prev_north_ff;
      heading_in     = heading_ff;
      dlat_mag_in    = dlat_mag_ff;
      dlat_neg_in    = dlat_neg_ff;
      dlon_mag_in    = dlon_mag_ff;
      dlon_neg_in    = dlon_neg_ff;
      amean_in       = amean_ff;
      fold_in        = fold_ff;
      speed_in       = speed_ff;
      fix_in         = fix_ff;
      pn_in          = pn_ff;
      pe_in          = pe_ff;
      e20_in         = e20_ff;
      east_in        = east_ff;
      north_in       = north_ff;
      cx_in          = cx_ff;
      cy_in          = cy_ff;
      cz_in          = cz_ff;
      ci_in          = ci_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_east_in    = rsp_east_ff;
      rsp_north_in   = rsp_north_ff;
      rsp_heading_in = rsp_heading_ff;
      rsp_fix_in     = rsp_fix_ff;

      // Take register writes
      if (csr_write) begin
         unique case (csr_index)
            CSR_EARTH_RADIUS:   radius_in    = csr_data;
            CSR_MOVE_THRESHOLD: threshold_in = csr_data[15:0];
            default:            radius_in    = radius_ff;
         endcase
      end

      // Drop the result word once taken
      if (rsp_valid_ff && rsp_channel.ready) begin
         rsp_valid_in = 1'b0;
      end

      if (mul_cmd.start) begin
         wait_in = 1'b1;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_channel.valid) begin
               speed_in    = req_channel.ground_speed_mm_s;
               dlat_mag_in = dlat[31] ? 32'(-dlat) : 32'(dlat);
               dlat_neg_in = dlat[31];
               dlon_mag_in = dlon[32] ? 33'(-dlon) : 33'(dlon);
               dlon_neg_in = dlon[32];
               fold_in     = mean_fold;
               amean_in    = mean_fold ? (HALF_TURN_E7 - mean_mag) : mean_mag;
               if (!origin_set_ff) begin
                  origin_set_in = 1'b1;
                  origin_lat_in = req_channel.latitude_e7;
                  origin_lon_in = req_channel.longitude_e7;
                  prev_east_in  = '0;
                  prev_north_in = '0;
                  heading_in    = '0;
                  east_in       = '0;
                  north_in      = '0;
                  fix_in        = 1'b1;
                  state_in      = S_DONE;
               end else begin
                  fix_in   = 1'b0;
                  state_in = S_PN;
               end
            end
         end
         S_PN: begin
            if (mul_done) begin
               pn_in    = mul_p[53:0];
               wait_in  = 1'b0;
               state_in = S_PE;
            end
         end
         S_PE: begin
            if (mul_done) begin
               pe_in    = mul_p[55:0];
               wait_in  = 1'b0;
               state_in = S_NORTH;
            end
         end
         S_NORTH: begin
            if (mul_done) begin
               north_in = sat32(mul_p[123:60], dlat_neg_ff);
               wait_in  = 1'b0;
               state_in = S_E20;
            end
         end
         S_E20: begin
            if (mul_done) begin
               e20_in   = mul_p[96:40];
               wait_in  = 1'b0;
               state_in = S_THETA;
            end
         end
         S_THETA: begin
            if (mul_done) begin
               cx_in    = 60'(CORDIC_INV_GAIN);
               cy_in    = '0;
               cz_in    = signed'({2'b00, mul_p[63:32]});
               ci_in    = '0;
               wait_in  = 1'b0;
               state_in = S_COS;
            end
         end
         S_COS: begin
            cx_in = cx_step;
            cy_in = cy_step;
            cz_in = cz_step;
            ci_in = ci_ff + 5'd1;
            if (ci_ff == LAST_STEP) begin
               state_in = S_EAST;
            end
         end
         S_EAST: begin
            if (mul_done) begin
               east_in  = sat32(mul_p[113:50], dlon_neg_ff ^ cx_ff[59] ^ fold_ff);
               wait_in  = 1'b0;
               state_in = S_HEAD;
            end
         end
         S_HEAD: begin
            prev_east_in  = east_ff;
            prev_north_in = north_ff;
            ci_in         = '0;
            if (update) begin
               if (x0[59]) begin
                  if (!y0[59]) begin
                     cx_in = y0;
                     cy_in = -x0;
                     cz_in = 34'(HALF_PI_Q30);
                  end else begin
                     cx_in = -y0;
                     cy_in = x0;
                     cz_in = -34'(HALF_PI_Q30);
                  end
               end else begin
                  cx_in = x0;
                  cy_in = y0;
                  cz_in = '0;
               end
               state_in = S_ATAN;
            end else begin
               state_in = S_DONE;
            end
         end
         S_ATAN: begin
            cx_in = cx_step;
            cy_in = cy_step;
            cz_in = cz_step;
            ci_in = ci_ff + 5'd1;
            if (ci_ff == LAST_STEP) begin
               state_in = S_BAM;
            end
         end
         S_BAM: begin
            if (mul_done) begin
               heading_in = cz_ff[33] ? bam_neg : bam_m[15:0];
               wait_in    = 1'b0;
               state_in   = S_DONE;
            end
         end
         S_DONE: begin
            // Load the result word when the output register is free
            if (!rsp_valid_ff || rsp_channel.ready) begin
               rsp_valid_in   = 1'b1;
               rsp_east_in    = east_ff;
               rsp_north_in   = north_ff;
               rsp_heading_in = heading_ff;
               rsp_fix_in     = fix_ff;
               state_in       = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         wait_ff       <= 1'b0;
         radius_ff     <= EARTH_RADIUS_RESET;
         threshold_ff  <= MOVE_THRESHOLD_RESET;
         origin_set_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         wait_ff       <= wait_in;
         radius_ff     <= radius_in;
         threshold_ff  <= threshold_in;
         origin_set_ff <= origin_set_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      origin_lat_ff  <= origin_lat_in;
      origin_lon_ff  <= origin_lon_in;
      prev_east_ff   <= prev_east_in;
      prev_north_ff  <= prev_north_in;
      heading_ff     <= heading_in;
      dlat_mag_ff    <= dlat_mag_in;
      dlat_neg_ff    <= dlat_neg_in;
      dlon_mag_ff    <= dlon_mag_in;
      dlon_neg_ff    <= dlon_neg_in;
      amean_ff       <= amean_in;
      fold_ff        <= fold_in;
      speed_ff       <= speed_in;
      fix_ff         <= fix_in;
      pn_ff          <= pn_in;
      pe_ff          <= pe_in;
      e20_ff         <= e20_in;
      east_ff        <= east_in;
      north_ff       <= north_in;
      cx_ff          <= cx_in;
      cy_ff          <= cy_in;
      cz_ff          <= cz_in;
      ci_ff          <= ci_in;
      rsp_east_ff    <= rsp_east_in;
      rsp_north_ff   <= rsp_north_in;
      rsp_heading_ff <= rsp_heading_in;
      rsp_fix_ff     <= rsp_fix_in;
   end

   assign req_channel.ready       = (state_ff == S_IDLE);
   assign rsp_channel.valid       = rsp_valid_ff;
   assign rsp_channel.east_mm     = rsp_east_ff;
   assign rsp_channel.north_mm    = rsp_north_ff;
   assign rsp_channel.heading_bam = rsp_heading_ff;
   assign rsp_channel.origin_fix  = rsp_fix_ff;

endmodule
